// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gcd_pkg.sv =====
// ----------------------------------------------------------------------------
// gcd_pkg
// shared widths and the item type passed from front to back
// ----------------------------------------------------------------------------
package gcd_pkg;

    localparam int OPB    = 31;
    localparam int MULT_W = 62;
    localparam int CNT_W  = $clog2(OPB + 1);

    typedef struct packed {
        logic [OPB-1:0] a;
        logic [OPB-1:0] b;
        logic           zero;
    } gcd_item_t;

endpackage

// ===== rtl/gcd_front.sv =====
// ----------------------------------------------------------------------------
// gcd_front
// accepts an item, flags a zero operand and hands it to the queue
// ----------------------------------------------------------------------------
module gcd_front
    import gcd_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [OPB-1:0] first_value,
    input  logic [OPB-1:0] second_value,
    output logic           busy,
    input  logic           q_full,
    output logic           push,
    output gcd_item_t      push_item
);

    logic      valid_reg;
    logic      valid_next;
    gcd_item_t item_reg;

    assign busy      = valid_reg;
    assign push      = valid_reg && !q_full;
    assign push_item = item_reg;

    // holding register valid flag
    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b0;
        end
        if (start && !busy)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // capture and classify
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            item_reg.a    <= first_value;
            item_reg.b    <= second_value;
            item_reg.zero <= (first_value == '0) || (second_value == '0);
        end
    end

endmodule

// ===== rtl/gcd_queue.sv =====
// ----------------------------------------------------------------------------
// gcd_queue
// two-entry item queue between front and back
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gcd_queue
    import gcd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  gcd_item_t push_item,
    input  logic      pop,
    output gcd_item_t pop_item,
    output logic      full,
    output logic      not_empty
);

    gcd_item_t   slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    `ASSERT_IMP(a_no_overflow, clk, rst_n, push, !full || pop, "queue overflow")
    `ASSERT_IMP(a_no_underflow, clk, rst_n, pop, not_empty, "queue underflow")

endmodule

// ===== rtl/gcd_back.sv =====
// ----------------------------------------------------------------------------
// gcd_back
// binary gcd, restoring division of the first operand, then one multiply
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gcd_back
    import gcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  gcd_item_t         q_item,
    output logic              pop,
    output logic              done,
    output logic [OPB-1:0]    divisor,
    output logic [MULT_W-1:0] multiple,
    output logic              zero_operand
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_GCD  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;

    logic [2:0]        state_reg, state_next;
    logic              done_reg, done_next;
    logic [OPB-1:0]    a_reg, a_next;
    logic [OPB-1:0]    b_reg, b_next;
    logic [OPB-1:0]    a0_reg, a0_next;
    logic [OPB-1:0]    b0_reg, b0_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [OPB-1:0]    g_reg, g_next;
    logic [OPB-1:0]    rem_reg, rem_next;
    logic [OPB-1:0]    dvd_reg, dvd_next;
    logic [OPB-1:0]    quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [MULT_W-1:0] mult_reg, mult_next;
    logic              zero_reg, zero_next;
    logic [OPB:0]      trial;
    logic [OPB:0]      trial_sub;
    logic [MULT_W-1:0] product;

    assign pop          = (state_reg == ST_IDLE) && q_valid;
    assign done         = done_reg;
    assign divisor      = g_reg;
    assign multiple     = mult_reg;
    assign zero_operand = zero_reg;

    // one restoring division step
    assign trial     = {rem_reg, dvd_reg[OPB-1]};
    assign trial_sub = trial - {1'b0, g_reg};

    // full-width product of quotient and second operand
    assign product = quo_reg * b0_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        a_next     = a_reg;
        b_next     = b_reg;
        a0_next    = a0_reg;
        b0_next    = b0_reg;
        k_next     = k_reg;
        g_next     = g_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        mult_next  = mult_reg;
        zero_next  = zero_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    a_next    = q_item.a;
                    b_next    = q_item.b;
                    a0_next   = q_item.a;
                    b0_next   = q_item.b;
                    k_next    = '0;
                    zero_next = q_item.zero;
                    if (q_item.zero)
                    begin
                        g_next    = q_item.a | q_item.b;
                        mult_next = '0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_GCD;
                    end
                end
            end
            ST_GCD:
            begin
                if (a_reg == b_reg)
                begin
                    g_next     = a_reg << k_reg;
                    rem_next   = '0;
                    dvd_next   = a0_reg;
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
                else if (!a_reg[0] && !b_reg[0])
                begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
                else if (!a_reg[0])
                begin
                    a_next = a_reg >> 1;
                end
                else if (!b_reg[0])
                begin
                    b_next = b_reg >> 1;
                end
                else if (a_reg > b_reg)
                begin
                    a_next = (a_reg - b_reg) >> 1;
                end
                else
                begin
                    b_next = (b_reg - a_reg) >> 1;
                end
            end
            ST_DIV:
            begin
                dvd_next = dvd_reg << 1;
                if (!trial_sub[OPB])
                begin
                    rem_next = trial_sub[OPB-1:0];
                    quo_next = {quo_reg[OPB-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[OPB-1:0];
                    quo_next = {quo_reg[OPB-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(OPB - 1))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                mult_next  = product;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        a0_reg   <= a0_next;
        b0_reg   <= b0_next;
        k_reg    <= k_next;
        g_reg    <= g_next;
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        quo_reg  <= quo_next;
        cnt_reg  <= cnt_next;
        mult_reg <= mult_next;
        zero_reg <= zero_next;
    end

    `ASSERT_NXT(a_mul_done, clk, rst_n, state_reg == ST_MUL, done_reg, "missing strobe")
    `ASSERT_IMP(a_zero_mult, clk, rst_n, done_reg && zero_reg, mult_reg == '0, "zero lcm")
    `ASSERT_IMP(a_pop_idle, clk, rst_n, done_reg, state_reg == ST_IDLE, "strobe while busy")

endmodule

// ===== rtl/gcd_lcm_unit.sv =====
// ----------------------------------------------------------------------------
// gcd_lcm_unit
// gcd and lcm of two 31-bit unsigned operands
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. The front stage
// flags a zero operand and passes the item to a two-entry queue; the back
// stage runs a binary gcd one step per cycle, then a 31-step restoring
// division of the first operand by the gcd and one 31x31 multiply. A
// result is shown for one cycle with done high. A zero operand skips the
// gcd loop, the division and the multiply and goes from the queue straight
// to the done register. Throughput is one item per back-stage run. The
// receiver cannot stall: done is a single cycle strobe. Reset empties the
// front register, the queue and the back sequencer; no item is in flight
// afterward.
// ----------------------------------------------------------------------------
module gcd_lcm_unit
    import gcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OPB-1:0]    first_value,
    input  logic [OPB-1:0]    second_value,
    output logic              done,
    output logic [OPB-1:0]    divisor,
    output logic [MULT_W-1:0] multiple,
    output logic              zero_operand
);

    logic      q_full;
    logic      q_valid;
    logic      push;
    logic      pop;
    gcd_item_t push_item;
    gcd_item_t pop_item;

    // accept and classify
    gcd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .first_value  (first_value),
        .second_value (second_value),
        .busy         (busy),
        .q_full       (q_full),
        .push         (push),
        .push_item    (push_item)
    );

    // decoupling queue
    gcd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .full      (q_full),
        .not_empty (q_valid)
    );

    // compute
    gcd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (pop_item),
        .pop          (pop),
        .done         (done),
        .divisor      (divisor),
        .multiple     (multiple),
        .zero_operand (zero_operand)
    );

endmodule
